/* design/tsb_pkg.sv */
package tsb_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam logic [31:0] BANDWIDTH_RESET = 32'd1024;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned SIZE_W = 27;
  localparam int unsigned BUD_W  = 32;
  localparam int unsigned QCNT_W = 5;

  // request codes
  localparam logic [1:0] REQ_ENQ    = 2'd0;
  localparam logic [1:0] REQ_BUDGET = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FIN  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   tag;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] remain;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_BUD,
    S_TICK
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACK_OVF,
    CMD_FIN,
    CMD_LOAD_INS,
    CMD_LOAD_BUD,
    CMD_LOAD_TICK,
    CMD_INS,
    CMD_BUD,
    CMD_TICK
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } status_t;

endpackage

/* design/transfer_scheduler_srpt_budget_core.sv */
// Shortest-remaining-first transfer queue. Results leave on result_valid for exactly one
// cycle each and cannot be held off, so the receiver must take every beat as it comes.
// A request is taken when start is high and busy is low; for a request that walks the
// queue, busy stays high until the last beat of that request has been issued, and a
// request answered at once never raises busy. An enqueue walks down from the tail past
// every queued entry with at least as many remaining bytes; a budget request walks
// every queued entry from the head and gives its completion beats in queue order; a
// tick lowers the head entry's remaining bytes by bandwidth, down to zero. An overflowing
// enqueue, a tick on an empty queue or an unused code is answered at once. The entry
// memory has a single read port and is walked one entry per cycle. bandwidth may be
// written at any idle time through cfg_we.
module transfer_scheduler_srpt_budget_core #(
  parameter int unsigned QUEUE_DEPTH = tsb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // request beat
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [tsb_pkg::ID_W-1:0]    resource_id,
  input  logic [tsb_pkg::SIZE_W-1:0]  total_size,
  input  logic [tsb_pkg::SIZE_W-1:0]  already_done,
  input  logic [tsb_pkg::BUD_W-1:0]   budget,
  // bandwidth register write
  input  logic                        cfg_we,
  input  logic [tsb_pkg::BUD_W-1:0]   cfg_data,
  // result beat
  output logic                        result_valid,
  output logic [1:0]                  kind,
  output logic [tsb_pkg::ID_W-1:0]    done_id,
  output logic [tsb_pkg::SIZE_W-1:0]  done_size,
  output logic [tsb_pkg::QCNT_W-1:0]  queue_count,
  output logic                        overflow,
  output logic                        last
);

  // command from the sequencer, status back from the datapath
  tsb_pkg::cmd_t    cmd;
  tsb_pkg::status_t status;
  // the walk of the current request has issued its last beat
  logic             fin;

  // sequencer: picks the walk for each request and ends it on the datapath's finish flag
  tsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .status   (status),
    .fin      (fin),
    .cmd      (cmd),
    .busy     (busy)
  );

  // datapath: entry memory, entry count, budget left, bandwidth and the result register
  tsb_datapath #(
    .DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .fin          (fin),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .resource_id  (resource_id),
    .total_size   (total_size),
    .already_done (already_done),
    .budget       (budget),
    .result_valid (result_valid),
    .kind         (kind),
    .done_id      (done_id),
    .done_size    (done_size),
    .queue_count  (queue_count),
    .overflow     (overflow),
    .last         (last)
  );

endmodule

/* design/tsb_ctrl.sv */
module tsb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       req_type,
  input  tsb_pkg::status_t status,
  input  logic             fin,
  output tsb_pkg::cmd_t    cmd,
  output logic             busy
);

  tsb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tsb_pkg::S_IDLE: begin
        if (start) begin
          unique case (req_type)
            tsb_pkg::REQ_ENQ: begin
              if (!status.full) state_next = tsb_pkg::S_INS;
            end
            tsb_pkg::REQ_BUDGET: state_next = tsb_pkg::S_BUD;
            tsb_pkg::REQ_TICK: begin
              if (!status.empty) state_next = tsb_pkg::S_TICK;
            end
            default: state_next = tsb_pkg::S_IDLE;
          endcase
        end
      end
      tsb_pkg::S_INS, tsb_pkg::S_BUD, tsb_pkg::S_TICK: begin
        if (fin) state_next = tsb_pkg::S_IDLE;
      end
      default: state_next = tsb_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = tsb_pkg::CMD_NONE;
    busy = (state != tsb_pkg::S_IDLE);
    unique case (state)
      tsb_pkg::S_IDLE: begin
        if (start) begin
          unique case (req_type)
            tsb_pkg::REQ_ENQ: begin
              cmd = status.full ? tsb_pkg::CMD_ACK_OVF : tsb_pkg::CMD_LOAD_INS;
            end
            tsb_pkg::REQ_BUDGET: cmd = tsb_pkg::CMD_LOAD_BUD;
            tsb_pkg::REQ_TICK: begin
              cmd = status.empty ? tsb_pkg::CMD_FIN : tsb_pkg::CMD_LOAD_TICK;
            end
            default: cmd = tsb_pkg::CMD_FIN;
          endcase
        end
      end
      tsb_pkg::S_INS:  cmd = tsb_pkg::CMD_INS;
      tsb_pkg::S_BUD:  cmd = tsb_pkg::CMD_BUD;
      tsb_pkg::S_TICK: cmd = tsb_pkg::CMD_TICK;
      default:         cmd = tsb_pkg::CMD_NONE;
    endcase
  end

endmodule

/* design/tsb_datapath.sv */
module tsb_datapath #(
  parameter int unsigned DEPTH = tsb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tsb_pkg::cmd_t                cmd,
  output tsb_pkg::status_t             status,
  output logic                         fin,
  input  logic                         cfg_we,
  input  logic [tsb_pkg::BUD_W-1:0]    cfg_data,
  input  logic [tsb_pkg::ID_W-1:0]     resource_id,
  input  logic [tsb_pkg::SIZE_W-1:0]   total_size,
  input  logic [tsb_pkg::SIZE_W-1:0]   already_done,
  input  logic [tsb_pkg::BUD_W-1:0]    budget,
  output logic                         result_valid,
  output logic [1:0]                   kind,
  output logic [tsb_pkg::ID_W-1:0]     done_id,
  output logic [tsb_pkg::SIZE_W-1:0]   done_size,
  output logic [tsb_pkg::QCNT_W-1:0]   queue_count,
  output logic                         overflow,
  output logic                         last
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PADW = tsb_pkg::BUD_W - tsb_pkg::SIZE_W;

  tsb_pkg::entry_t mem [DEPTH];

  logic [CW-1:0]              count, count_next;
  tsb_pkg::entry_t            new_e, new_e_next;
  logic [tsb_pkg::BUD_W-1:0]  load, load_next;
  logic [tsb_pkg::BUD_W-1:0]  bandwidth;
  logic [AW-1:0]              rd_ptr, rd_ptr_next;
  logic [AW-1:0]              walk_end, walk_end_next;
  logic                       rd_more, rd_more_next;
  tsb_pkg::entry_t            rd_q;
  logic                       dv, dv_next;
  logic [AW-1:0]              dptr, dptr_next;
  logic [AW-1:0]              keep, keep_next;

  logic                       we;
  logic [AW-1:0]              waddr;
  tsb_pkg::entry_t            wdata;

  logic                       emit;
  logic [1:0]                 e_kind;
  logic [tsb_pkg::ID_W-1:0]   e_id;
  logic [tsb_pkg::SIZE_W-1:0] e_size;
  logic [CW-1:0]              e_cnt;
  logic                       e_ovf;
  logic                       e_last;

  logic [tsb_pkg::SIZE_W-1:0] in_rem;
  logic [CW-1:0]              cnt_m1;
  logic [CW-1:0]              cnt_p1;
  logic [tsb_pkg::BUD_W-1:0]  q_rem_ext;
  logic [CW+tsb_pkg::QCNT_W-1:0] qc_ext;

  assign in_rem    = (already_done >= total_size) ? '0 : total_size - already_done;
  assign cnt_m1    = count - CW'(1);
  assign cnt_p1    = count + CW'(1);
  assign q_rem_ext = {{PADW{1'b0}}, rd_q.remain};

  assign status.full  = (count >= CW'(DEPTH));
  assign status.empty = (count == '0);

  always_comb begin
    count_next    = count;
    new_e_next    = new_e;
    load_next     = load;
    rd_ptr_next   = rd_ptr;
    walk_end_next = walk_end;
    rd_more_next  = rd_more;
    dv_next       = dv;
    dptr_next     = dptr;
    keep_next     = keep;
    we            = 1'b0;
    waddr         = '0;
    wdata         = rd_q;
    emit          = 1'b0;
    e_kind        = tsb_pkg::KIND_FIN;
    e_id          = '0;
    e_size        = '0;
    e_cnt         = count;
    e_ovf         = 1'b0;
    e_last        = 1'b0;
    fin           = 1'b0;
    unique case (cmd)
      tsb_pkg::CMD_ACK_OVF: begin
        emit   = 1'b1;
        e_kind = tsb_pkg::KIND_ACK;
        e_ovf  = 1'b1;
        e_last = 1'b1;
      end
      tsb_pkg::CMD_FIN: begin
        emit   = 1'b1;
        e_last = 1'b1;
      end
      tsb_pkg::CMD_LOAD_INS: begin
        new_e_next.tag    = resource_id;
        new_e_next.size   = total_size;
        new_e_next.remain = in_rem;
        rd_ptr_next       = cnt_m1[AW-1:0];
        rd_more_next      = (count != '0);
        dv_next           = 1'b0;
      end
      tsb_pkg::CMD_LOAD_BUD: begin
        load_next     = budget;
        rd_ptr_next   = '0;
        walk_end_next = cnt_m1[AW-1:0];
        rd_more_next  = (count != '0);
        dv_next       = 1'b0;
        keep_next     = '0;
      end
      tsb_pkg::CMD_LOAD_TICK: begin
        rd_ptr_next  = '0;
        rd_more_next = 1'b1;
        dv_next      = 1'b0;
      end
      tsb_pkg::CMD_INS: begin
        // walk down from the tail, shifting entries with at least as many remaining bytes up by one
        dv_next   = rd_more;
        dptr_next = rd_ptr;
        if (rd_more) begin
          if (rd_ptr == '0) begin
            rd_more_next = 1'b0;
          end else begin
            rd_ptr_next = rd_ptr - AW'(1);
          end
        end
        if (dv && (rd_q.remain >= new_e.remain)) begin
          we    = 1'b1;
          waddr = dptr + AW'(1);
          wdata = rd_q;
        end else if (dv || !rd_more) begin
          we         = 1'b1;
          waddr      = dv ? dptr + AW'(1) : '0;
          wdata      = new_e;
          count_next = cnt_p1;
          emit       = 1'b1;
          e_kind     = tsb_pkg::KIND_ACK;
          e_cnt      = cnt_p1;
          e_last     = 1'b1;
          fin        = 1'b1;
        end
      end
      tsb_pkg::CMD_BUD: begin
        // walk up from the head, compacting the kept entries
        dv_next = rd_more;
        if (rd_more) begin
          rd_ptr_next  = rd_ptr + AW'(1);
          rd_more_next = (rd_ptr != walk_end);
        end
        if (dv) begin
          if (q_rem_ext > load) begin
            we           = 1'b1;
            waddr        = keep;
            wdata        = rd_q;
            wdata.remain = rd_q.remain - load[tsb_pkg::SIZE_W-1:0];
            keep_next    = keep + AW'(1);
            load_next    = '0;
          end else begin
            load_next  = load - q_rem_ext;
            count_next = cnt_m1;
            emit       = 1'b1;
            e_kind     = tsb_pkg::KIND_DONE;
            e_id       = rd_q.tag;
            e_size     = rd_q.size;
            e_cnt      = cnt_m1;
          end
        end else if (!rd_more) begin
          emit   = 1'b1;
          e_last = 1'b1;
          fin    = 1'b1;
        end
      end
      tsb_pkg::CMD_TICK: begin
        dv_next      = 1'b1;
        rd_more_next = 1'b0;
        if (dv) begin
          we           = 1'b1;
          waddr        = '0;
          wdata        = rd_q;
          wdata.remain = (q_rem_ext > bandwidth) ?
                         rd_q.remain - bandwidth[tsb_pkg::SIZE_W-1:0] : '0;
          emit         = 1'b1;
          e_last       = 1'b1;
          fin          = 1'b1;
        end
      end
      default: begin
        dv_next = dv;
      end
    endcase
  end

  assign qc_ext = {{tsb_pkg::QCNT_W{1'b0}}, e_cnt};

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      bandwidth <= tsb_pkg::BANDWIDTH_RESET;
      rd_more   <= 1'b0;
      dv        <= 1'b0;
    end else begin
      count   <= count_next;
      rd_more <= rd_more_next;
      dv      <= dv_next;
      if (cfg_we) begin
        bandwidth <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    new_e    <= new_e_next;
    load     <= load_next;
    rd_ptr   <= rd_ptr_next;
    walk_end <= walk_end_next;
    dptr     <= dptr_next;
    keep     <= keep_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= e_kind;
      done_id     <= e_id;
      done_size   <= e_size;
      queue_count <= qc_ext[tsb_pkg::QCNT_W-1:0];
      overflow    <= e_ovf;
      last        <= e_last;
    end
  end

endmodule
